### sv/tva_pkg.sv
// Shared types, constants and helpers for the tuned voice allocator.
// Used by tva_front, tva_back and tuned_voice_allocator; depends on nothing.
`default_nettype none

package tva_pkg;

  localparam int MAX_OUTPUTS   = 16;
  localparam int PITCH_CLASSES = 12;
  localparam int MAX_NOTES     = 32;
  localparam int NUM_SLOTS     = MAX_OUTPUTS * PITCH_CLASSES;
  localparam int QDEPTH        = 2;
  localparam int QPW           = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    EV_ON   = 2'd0,
    EV_OFF  = 2'd1,
    EV_TUNE = 2'd2
  } ev_kind_e;

  typedef enum logic {
    REQ_ON  = 1'b0,
    REQ_OFF = 1'b1
  } req_e;

  typedef enum logic {
    REG_NUM_OUTPUTS = 1'b0,
    REG_PC_MODE     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    req_e        req_type;
    logic [4:0]  note_id;
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [13:0] mod;
    logic [31:0] ts;
    logic [31:0] mt;
  } item_t;

  typedef struct packed {
    logic [3:0]  idx;
    ev_kind_e    kind;
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [13:0] mod;
    logic [31:0] tm;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [4:0] n_used;
    logic       pc_mode;
    logic       clear;
  } cfg_t;

  // Pitch class of a key, key mod 12, by reciprocal multiplication.
  function automatic logic [3:0] pclass(input logic [6:0] key);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(key) * 15'd171;
    q = p[14:11];
    r = key - 7'({q, 3'b000}) - 7'({q, 2'b00});
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

### sv/tuned_voice_allocator.sv
// Top level of the tuned voice allocator: configuration registers and the
// front and back ends. Uses tva_pkg, tva_front and tva_back.
//
//   Port group   Direction  Handshake             Payload
//   in_*         input      in_valid_i/in_ready_o   one note event per beat
//   out_*        output     out_valid_o/out_ready_i one result event per beat
//   cfg_*        input      cfg_we_i                register index and data
//
// A note-on reads the slot store once per scanned slot; a steal adds a sweep
// over every note tag in the note store. Note-offs and note-ons stall on output.
// The slot store is cleared by per-slot valid bits, so no clearing pass is needed.
// A two-beat queue lets input beats be taken while the back end works.
// Reset and every register write empty all slot and note state.
`default_nettype none

module tuned_voice_allocator import tva_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [4:0]  note_id_i,
  input  wire logic [3:0]  midi_channel_i,
  input  wire logic [6:0]  key_i,
  input  wire logic [6:0]  velocity_i,
  input  wire logic [13:0] mod_value_i,
  input  wire logic [31:0] timestamp_i,
  input  wire logic [31:0] mod_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       out_index_o,
  output logic [1:0]       event_kind_o,
  output logic [3:0]       out_channel_o,
  output logic [6:0]       out_key_o,
  output logic [6:0]       out_velocity_o,
  output logic [13:0]      out_mod_value_o,
  output logic [31:0]      out_time_o,
  output logic             last_o
);

  logic [4:0] num_q, num_d;
  logic       pcm_q, pcm_d;
  cfg_t       cfg;
  item_t      in_item, head;
  logic       head_valid, pop;
  res_t       res;

  always_comb begin
    num_d = num_q;
    pcm_d = pcm_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_NUM_OUTPUTS: num_d = cfg_data_i;
        REG_PC_MODE:     pcm_d = cfg_data_i[0];
        default:         num_d = num_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 5'(MAX_OUTPUTS);
      pcm_q <= 1'b0;
    end else begin
      num_q <= num_d;
      pcm_q <= pcm_d;
    end
  end

  assign cfg.n_used  = (num_q == 5'd0) ? 5'd1 :
                       (num_q > 5'(MAX_OUTPUTS)) ? 5'(MAX_OUTPUTS) : num_q;
  assign cfg.pc_mode = pcm_q;
  assign cfg.clear   = cfg_we_i;

  assign in_item = '{req_e'(req_type_i), note_id_i, midi_channel_i, key_i,
                     velocity_i, mod_value_i, timestamp_i, mod_time_i};

  tva_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tva_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign out_index_o     = res.idx;
  assign event_kind_o    = res.kind;
  assign out_channel_o   = res.chan;
  assign out_key_o       = res.key;
  assign out_velocity_o  = res.vel;
  assign out_mod_value_o = res.mod;
  assign out_time_o      = res.tm;
  assign last_o          = res.last;

endmodule

`default_nettype wire

### sv/tva_front.sv
// Front end of the tuned voice allocator: accepts input beats, drops
// zero-velocity note-ons and queues the rest for the back end. Uses tva_pkg.
`default_nettype none

module tva_front import tva_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  output logic       head_valid_o,
  output item_t      head_o,
  input  wire logic  pop_i
);

  item_t           q_mem [QDEPTH];
  logic [QPW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QPW:0]    cnt_q, cnt_d;
  logic            push;

  assign in_ready_o   = (cnt_q != (QPW+1)'(QDEPTH));
  assign push         = in_valid_i && in_ready_o &&
                        !(in_item_i.req_type == REQ_ON && in_item_i.vel == 7'd0);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == QPW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == QPW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### sv/tva_back.sv
// Back end of the tuned voice allocator: slot and note stores, the
// sequencer that places and releases notes, and the result register. Uses tva_pkg.
`default_nettype none

module tva_back import tva_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  head_valid_i,
  input  wire item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_o
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_REL_RD    = 11'b00000000010,
    S_REL_WR    = 11'b00000000100,
    S_OFF_EMIT  = 11'b00000001000,
    S_SCAN_RD   = 11'b00000010000,
    S_SCAN_EV   = 11'b00000100000,
    S_NT_RD     = 11'b00001000000,
    S_NT_EV     = 11'b00010000000,
    S_HOLD      = 11'b00100000000,
    S_EMIT_ON   = 11'b01000000000,
    S_EMIT_TUNE = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic [13:0] tun;
    logic [31:0] lu;
    logic [5:0]  cnt;
  } slot_ent_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [3:0] outi;
    logic [6:0] key;
  } note_ent_t;

  typedef struct packed {
    item_t       it;
    logic [3:0]  k;
    logic [4:0]  i;
    logic [7:0]  rel_slot;
    logic [3:0]  off_idx;
    logic        mf;
    logic [3:0]  mk;
    logic [5:0]  mc;
    logic        ef;
    logic [3:0]  ek;
    logic [31:0] elu;
    logic [3:0]  ak;
    logic [31:0] alu;
    logic [3:0]  ck;
    logic [5:0]  newcnt;
  } work_t;

  state_e                 st_q, st_d;
  work_t                  w_q, w_d;
  logic [31:0]            uc_q, uc_d;
  logic [MAX_NOTES-1:0]   act_q, act_d;
  logic [NUM_SLOTS-1:0]   svld_q, svld_d;
  logic                   ov_q, ov_d;
  res_t                   res_q, res_d;

  slot_ent_t  smem [NUM_SLOTS];
  note_ent_t  nmem [MAX_NOTES];
  slot_ent_t  srd_q;
  logic       svr_q;
  note_ent_t  nrd_q;

  logic        s_we, s_re, n_we, n_re;
  logic [7:0]  s_addr;
  slot_ent_t   s_wdata;
  logic [4:0]  n_addr;
  note_ent_t   n_wdata;
  logic        can_emit;
  logic [3:0]  kmax;
  logic [3:0]  pc;
  logic [31:0] lu_eff;
  logic [5:0]  cnt_eff;
  logic        hit;

  function automatic logic [7:0] slot_of(input logic pcm, input logic [3:0] first,
                                         input logic [3:0] k);
    if (pcm) begin
      return 8'(first) + 8'({k, 3'b000}) + 8'({k, 2'b00});
    end else begin
      return {4'b0000, k};
    end
  endfunction

  assign can_emit    = !ov_q || out_ready_i;
  assign kmax        = 4'(cfg_i.n_used - 5'd1);
  assign pc          = pclass(w_q.it.key);
  assign lu_eff      = svr_q ? srd_q.lu : 32'd0;
  assign cnt_eff     = svr_q ? srd_q.cnt : 6'd0;
  assign hit         = act_q[w_q.i] && (nrd_q.slot == slot_of(cfg_i.pc_mode, pc, w_q.ck));
  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  always_comb begin
    st_d    = st_q;
    w_d     = w_q;
    uc_d    = uc_q;
    act_d   = act_q;
    svld_d  = svld_q;
    ov_d    = ov_q;
    res_d   = res_q;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_addr  = slot_of(cfg_i.pc_mode, pc, w_q.k);
    s_wdata = '0;
    n_we    = 1'b0;
    n_re    = 1'b0;
    n_addr  = w_q.it.note_id;
    n_wdata = '0;
    pop_o   = 1'b0;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (head_valid_i && !cfg_i.clear) begin
          pop_o  = 1'b1;
          w_d.it = head_i;
          w_d.k  = '0;
          w_d.i  = '0;
          w_d.mf = 1'b0;
          w_d.ef = 1'b0;
          n_re   = 1'b1;
          n_addr = head_i.note_id;
          if (act_q[head_i.note_id]) begin
            st_d = S_REL_RD;
          end else if (head_i.req_type == REQ_ON) begin
            st_d = S_SCAN_RD;
          end
        end
      end
      S_REL_RD: begin
        w_d.rel_slot = nrd_q.slot;
        w_d.off_idx  = nrd_q.outi;
        s_re         = 1'b1;
        s_addr       = nrd_q.slot;
        st_d         = S_REL_WR;
      end
      S_REL_WR: begin
        if (svr_q && srd_q.cnt != 6'd0) begin
          s_we        = 1'b1;
          s_addr      = w_q.rel_slot;
          s_wdata     = srd_q;
          s_wdata.cnt = srd_q.cnt - 6'd1;
        end
        act_d[w_q.it.note_id] = 1'b0;
        st_d = (w_q.it.req_type == REQ_OFF) ? S_OFF_EMIT : S_SCAN_RD;
      end
      S_OFF_EMIT: begin
        if (can_emit) begin
          res_d = '{w_q.off_idx, EV_OFF, w_q.it.chan, w_q.it.key, w_q.it.vel,
                    14'd0, w_q.it.ts, 1'b1};
          ov_d  = 1'b1;
          st_d  = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        s_re = 1'b1;
        st_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (!w_q.mf && svr_q && srd_q.tun == w_q.it.mod) begin
          w_d.mf = 1'b1;
          w_d.mk = w_q.k;
          w_d.mc = cnt_eff;
        end
        if (cnt_eff == 6'd0 && (!w_q.ef || lu_eff < w_q.elu)) begin
          w_d.ef  = 1'b1;
          w_d.ek  = w_q.k;
          w_d.elu = lu_eff;
        end
        if (w_q.k == 4'd0 || lu_eff < w_q.alu) begin
          w_d.ak  = w_q.k;
          w_d.alu = lu_eff;
        end
        if (w_q.k == kmax) begin
          w_d.newcnt = 6'd1;
          if (w_d.mf) begin
            w_d.ck     = w_d.mk;
            w_d.newcnt = w_d.mc + 6'd1;
            st_d       = S_HOLD;
          end else if (w_d.ef) begin
            w_d.ck = w_d.ek;
            st_d   = S_HOLD;
          end else begin
            w_d.ck = w_d.ak;
            st_d   = S_NT_RD;
          end
        end else begin
          w_d.k = w_q.k + 4'd1;
          st_d  = S_SCAN_RD;
        end
      end
      S_NT_RD: begin
        n_re   = 1'b1;
        n_addr = w_q.i;
        st_d   = S_NT_EV;
      end
      S_NT_EV: begin
        if (!hit || can_emit) begin
          if (hit) begin
            res_d = '{w_q.ck, EV_OFF, w_q.it.chan, nrd_q.key, 7'd0,
                      14'd0, w_q.it.ts, 1'b0};
            ov_d  = 1'b1;
            act_d[w_q.i] = 1'b0;
          end
          if (w_q.i == 5'(MAX_NOTES - 1)) begin
            st_d = S_HOLD;
          end else begin
            w_d.i = w_q.i + 5'd1;
            st_d  = S_NT_RD;
          end
        end
      end
      S_HOLD: begin
        s_we    = 1'b1;
        s_addr  = slot_of(cfg_i.pc_mode, pc, w_q.ck);
        s_wdata = '{w_q.it.mod, uc_q + 32'd1, w_q.newcnt};
        svld_d[s_addr] = 1'b1;
        uc_d    = uc_q + 32'd1;
        n_we    = 1'b1;
        n_wdata = '{s_addr, w_q.ck, w_q.it.key};
        act_d[w_q.it.note_id] = 1'b1;
        st_d    = S_EMIT_ON;
      end
      S_EMIT_ON: begin
        if (can_emit) begin
          res_d = '{w_q.ck, EV_ON, w_q.it.chan, w_q.it.key, w_q.it.vel,
                    14'd0, w_q.it.ts, w_q.mf};
          ov_d  = 1'b1;
          st_d  = w_q.mf ? S_IDLE : S_EMIT_TUNE;
        end
      end
      S_EMIT_TUNE: begin
        if (can_emit) begin
          res_d = '{w_q.ck, EV_TUNE, w_q.it.chan, 7'd0, 7'd0,
                    w_q.it.mod, w_q.it.mt, 1'b1};
          ov_d  = 1'b1;
          st_d  = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
    if (cfg_i.clear) begin
      svld_d = '0;
      act_d  = '0;
      uc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      uc_q   <= '0;
      act_q  <= '0;
      svld_q <= '0;
      ov_q   <= 1'b0;
      svr_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      uc_q   <= uc_d;
      act_q  <= act_d;
      svld_q <= svld_d;
      ov_q   <= ov_d;
      if (s_re) begin
        svr_q <= svld_q[s_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_addr] <= s_wdata;
    end
    if (s_re) begin
      srd_q <= smem[s_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      nmem[n_addr] <= n_wdata;
    end
    if (n_re) begin
      nrd_q <= nmem[n_addr];
    end
  end

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench for tuned_voice_allocator: a queue-fed driver and a monitor that
// checks every result beat against an in-bench voice allocation predictor.
// Depends on tva_pkg and the tuned_voice_allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import tva_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [4:0]  note_id_i = '0;
  logic [3:0]  midi_channel_i = '0;
  logic [6:0]  key_i = '0;
  logic [6:0]  velocity_i = '0;
  logic [13:0] mod_value_i = '0;
  logic [31:0] timestamp_i = '0;
  logic [31:0] mod_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  out_index_o;
  logic [1:0]  event_kind_o;
  logic [3:0]  out_channel_o;
  logic [6:0]  out_key_o;
  logic [6:0]  out_velocity_o;
  logic [13:0] out_mod_value_o;
  logic [31:0] out_time_o;
  logic        last_o;

  tuned_voice_allocator DUT (.*);

  always #1 clk_i = ~clk_i;

  item_t pending_events[$];
  res_t  expected_events[$];
  int    error_count = 0;
  int    beats_sent = 0;
  bit    calm = 1'b0;

  logic [4:0]  reg_outputs = 5'd16;
  logic        reg_pc = 1'b0;
  logic [13:0] s_tune [NUM_SLOTS];
  bit          s_tvalid [NUM_SLOTS];
  logic [31:0] s_used [NUM_SLOTS];
  logic [5:0]  s_count [NUM_SLOTS];
  logic [7:0]  n_slot [MAX_NOTES];
  logic [6:0]  n_key [MAX_NOTES];
  bit          n_held [MAX_NOTES];
  logic [31:0] use_clock;

  function automatic void wipe_voices();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      s_tune[s] = '0; s_tvalid[s] = 0; s_used[s] = '0; s_count[s] = '0;
    end
    for (int i = 0; i < MAX_NOTES; i++) begin
      n_slot[i] = '0; n_key[i] = '0; n_held[i] = 0;
    end
    use_clock = '0;
  endfunction

  function automatic void push_event(int slot, ev_kind_e kind, item_t it, logic [6:0] key,
                                     logic [6:0] vel, logic [13:0] md, logic [31:0] tm);
    res_t r;
    r.idx = reg_pc ? 4'(slot / PITCH_CLASSES) : 4'(slot);
    r.kind = kind; r.chan = it.chan; r.key = key; r.vel = vel;
    r.mod = md; r.tm = tm; r.last = 1'b0;
    expected_events.push_back(r);
  endfunction

  function automatic void take_voice(int id, int slot, logic [6:0] key);
    n_held[id] = 1; n_slot[id] = 8'(slot); n_key[id] = key;
    s_count[slot]++;
    use_clock++;
    s_used[slot] = use_clock;
  endfunction

  function automatic void predict_allocation(item_t it);
    int n, first, stride, stop, best, id, mark;
    mark = expected_events.size();
    id = it.note_id;
    n = (reg_outputs < 1) ? 1 : (reg_outputs > MAX_OUTPUTS) ? MAX_OUTPUTS : reg_outputs;
    if (it.req_type == REQ_OFF) begin
      if (n_held[id]) begin
        push_event(n_slot[id], EV_OFF, it, it.key, it.vel, '0, it.ts);
        if (s_count[n_slot[id]] > 0) s_count[n_slot[id]]--;
        n_held[id] = 0;
      end
    end else if (it.vel != 0) begin
      if (n_held[id]) begin
        if (s_count[n_slot[id]] > 0) s_count[n_slot[id]]--;
        n_held[id] = 0;
      end
      first = reg_pc ? it.key % PITCH_CLASSES : 0;
      stride = reg_pc ? PITCH_CLASSES : 1;
      stop = reg_pc ? n * PITCH_CLASSES : n;
      best = -1;
      for (int s = first; s < stop; s += stride)
        if (best < 0 && s_tvalid[s] && s_tune[s] == it.mod) best = s;
      if (best >= 0) begin
        take_voice(id, best, it.key);
        push_event(best, EV_ON, it, it.key, it.vel, '0, it.ts);
      end else begin
        for (int s = first; s < stop; s += stride)
          if (s_count[s] == 0 && (best < 0 || s_used[s] < s_used[best])) best = s;
        if (best < 0) begin
          best = first;
          for (int s = first; s < stop; s += stride)
            if (s_used[s] < s_used[best]) best = s;
          for (int i = 0; i < MAX_NOTES; i++)
            if (n_held[i] && n_slot[i] == best) begin
              push_event(best, EV_OFF, it, n_key[i], '0, '0, it.ts);
              n_held[i] = 0;
            end
          s_count[best] = '0;
        end
        s_tune[best] = it.mod; s_tvalid[best] = 1;
        take_voice(id, best, it.key);
        push_event(best, EV_ON, it, it.key, it.vel, '0, it.ts);
        push_event(best, EV_TUNE, it, '0, '0, it.mod, it.mt);
      end
    end
    if (expected_events.size() > mark) expected_events[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("Mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_allocation(pending_events.pop_front());
      beats_sent++;
    end
    if ((!in_valid_i || in_ready_o) && pending_events.size() > 0 && rst_ni &&
        (calm || $urandom_range(99) >= 6)) begin
      in_valid_i <= 1'b1;
      req_type_i <= pending_events[0].req_type;
      note_id_i <= pending_events[0].note_id;
      midi_channel_i <= pending_events[0].chan;
      key_i <= pending_events[0].key;
      velocity_i <= pending_events[0].vel;
      mod_value_i <= pending_events[0].mod;
      timestamp_i <= pending_events[0].ts;
      mod_time_i <= pending_events[0].mt;
    end else if (in_ready_o) begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    res_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        w = expected_events.pop_front();
        if (out_index_o !== w.idx) report_mismatch($sformatf("out_index %0d vs %0d",
          out_index_o, w.idx));
        if (event_kind_o !== w.kind) report_mismatch($sformatf("event_kind %0d vs %0d",
          event_kind_o, w.kind));
        if (out_channel_o !== w.chan) report_mismatch("out_channel");
        if (out_key_o !== w.key) report_mismatch($sformatf("out_key %0d vs %0d",
          out_key_o, w.key));
        if (out_velocity_o !== w.vel) report_mismatch("out_velocity");
        if (out_mod_value_o !== w.mod) report_mismatch("out_mod_value");
        if (out_time_o !== w.tm) report_mismatch("out_time");
        if (last_o !== w.last) report_mismatch("last");
      end
    end
    out_ready_i <= rst_ni && (calm || $urandom_range(99) >= 6);
  end

  function automatic item_t make_event(req_e rt, int id, int key, int vel, int md);
    item_t it;
    it.req_type = rt; it.note_id = 5'(id); it.chan = 4'($urandom);
    it.key = 7'(key); it.vel = 7'(vel); it.mod = 14'(md);
    it.ts = $urandom; it.mt = $urandom;
    return it;
  endfunction

  task automatic drain();
    while (pending_events.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NUM_OUTPUTS) reg_outputs = val; else reg_pc = val[0];
    wipe_voices();
  endtask

  task automatic random_phase(int count, int ids, int tunes);
    for (int k = 0; k < count; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 55)
        pending_events.push_back(make_event(REQ_ON, $urandom_range(ids - 1),
          $urandom_range(127), $urandom_range(1, 127),
          (r < 45) ? $urandom_range(tunes - 1) : $urandom_range(16383)));
      else if (r < 90)
        pending_events.push_back(make_event(REQ_OFF, $urandom_range(ids - 1),
          $urandom_range(127), $urandom_range(127), $urandom_range(16383)));
      else
        pending_events.push_back(make_event(req_e'($urandom_range(1)), $urandom,
          $urandom_range(127), (r < 95) ? 0 : $urandom_range(127), $urandom));
    end
  endtask

  initial begin
    wipe_voices();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(REG_NUM_OUTPUTS, 5'd2);
    pending_events.push_back(make_event(REQ_ON, 0, 0, 127, 0));
    pending_events.push_back(make_event(REQ_ON, 1, 127, 1, 16383));
    pending_events.push_back(make_event(REQ_ON, 2, 60, 64, 0));
    pending_events.push_back(make_event(REQ_ON, 3, 61, 64, 500));
    pending_events.push_back(make_event(REQ_ON, 4, 62, 64, 700));
    pending_events.push_back(make_event(REQ_ON, 31, 5, 0, 9));
    pending_events.push_back(make_event(REQ_ON, 4, 63, 90, 16383));
    pending_events.push_back(make_event(REQ_OFF, 1, 127, 0, 0));
    pending_events.push_back(make_event(REQ_OFF, 4, 63, 127, 0));
    pending_events.push_back(make_event(REQ_OFF, 20, 10, 10, 0));
    pending_events.push_back(make_event(REQ_OFF, 2, 60, 5, 0));
    drain();
    write_reg(REG_PC_MODE, 5'd1);
    write_reg(REG_NUM_OUTPUTS, 5'd1);
    for (int i = 0; i < 4; i++)
      pending_events.push_back(make_event(REQ_ON, i, 12 * i + 3, 100, i));
    pending_events.push_back(make_event(REQ_ON, 9, 4, 100, 1));
    pending_events.push_back(make_event(REQ_OFF, 0, 3, 1, 0));
    drain();
    write_reg(REG_NUM_OUTPUTS, 5'd16);
    random_phase(70, 32, 40);
    drain();
    write_reg(REG_PC_MODE, 5'd0);
    calm = 1'b1;
    random_phase(40, 32, 20);
    drain();
    calm = 1'b0;
    write_reg(REG_NUM_OUTPUTS, 5'd0);
    random_phase(50, 8, 6);
    drain();
    write_reg(REG_NUM_OUTPUTS, 5'd31);
    random_phase(50, 32, 24);
    drain();
    write_reg(REG_NUM_OUTPUTS, 5'd3);
    write_reg(REG_PC_MODE, 5'd1);
    random_phase(60, 16, 8);
    drain();
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

### filelist.f
sv/tva_pkg.sv
sv/tva_front.sv
sv/tva_back.sv
sv/tuned_voice_allocator.sv
test/testbench.sv
